// ===== hw/rtl/cen_pkg.sv =====
// Census transform package: item types, register indexes, reset values and
// the tap bundle passed from the window to the code logic. No dependencies.
package cen_pkg;

    localparam int PIX_W  = 16;
    localparam int CODE_W = 16;
    localparam int COL_W  = 11;
    localparam int ROW_W  = 12;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;
    localparam int IW_W   = 12;
    localparam int GAIN_W = 16;
    localparam int FRAC_W = 12;   // Q4.12 gains
    localparam int NB_N   = 8;

    localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MODE_TWO_BIT = 2'd1;
    localparam logic [CIDX_W-1:0] REG_UPPER_GAIN   = 2'd2;
    localparam logic [CIDX_W-1:0] REG_LOWER_GAIN   = 2'd3;

    localparam logic [IW_W-1:0]   RST_IMAGE_WIDTH = 12'd640;
    localparam logic [GAIN_W-1:0] RST_UPPER_GAIN  = 16'd4506;
    localparam logic [GAIN_W-1:0] RST_LOWER_GAIN  = 16'd3686;
    localparam int                MIN_WIDTH       = 3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } cen_in_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [COL_W-1:0]  center_col;
        logic [ROW_W-1:0]  center_row;
    } cen_out_t;

    // neighbours in census order, plus the centre
    typedef struct packed {
        logic [NB_N-1:0][PIX_W-1:0] nb;
        logic [PIX_W-1:0]           ctr;
    } cen_taps_t;

    typedef struct packed {
        logic             mode_two_bit;
        logic [GAIN_W-1:0] upper_gain;
        logic [GAIN_W-1:0] lower_gain;
    } cen_code_cfg_t;

endpackage

// ===== hw/rtl/cen_line_buf.sv =====
// Two line stores (row above, two rows above) with registered read and
// same-address forwarding of the write issued at the read edge. Uses cen_pkg.
module cen_line_buf
    import cen_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_a,
    input  logic [PIX_W-1:0] wr_b,
    output logic [PIX_W-1:0] mid,
    output logic [PIX_W-1:0] top
);

    logic [PIX_W-1:0] mem_a [DEPTH];
    logic [PIX_W-1:0] mem_b [DEPTH];

    logic [PIX_W-1:0] rd_a_reg;
    logic [PIX_W-1:0] rd_b_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_a_reg;
    logic [PIX_W-1:0] fwd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_a[wr_addr] <= wr_a;
            mem_b[wr_addr] <= wr_b;
        end
    end

    // read returns old contents on a collision, so the written item is kept aside
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg  <= mem_a[rd_addr];
            rd_b_reg  <= mem_b[rd_addr];
            fwd_reg   <= wr_en && (wr_addr == rd_addr);
            fwd_a_reg <= wr_a;
            fwd_b_reg <= wr_b;
        end
    end

    assign mid = fwd_reg ? fwd_a_reg : rd_a_reg;
    assign top = fwd_reg ? fwd_b_reg : rd_b_reg;

endmodule

// ===== hw/rtl/cen_code.sv =====
// Census code logic: one-bit greater-than or two-bit ternary compare of the
// eight neighbours against the centre. Uses cen_pkg.
module cen_code
    import cen_pkg::*;
(
    input  cen_taps_t         taps,
    input  cen_code_cfg_t     cfg,
    output logic [CODE_W-1:0] code
);

    localparam int PROD_W = PIX_W + GAIN_W;

    logic [PROD_W-1:0] up_thr;
    logic [PROD_W-1:0] lo_thr;
    logic [PROD_W-1:0] lhs [NB_N];
    logic [NB_N-1:0]   gt_ctr;
    logic [NB_N-1:0]   gt_up;
    logic [NB_N-1:0]   gt_lo;

    assign up_thr = PROD_W'(taps.ctr) * PROD_W'(cfg.upper_gain);
    assign lo_thr = PROD_W'(taps.ctr) * PROD_W'(cfg.lower_gain);

    always_comb begin
        for (int k = 0; k < NB_N; k++) begin
            lhs[k]    = PROD_W'(taps.nb[k]) << FRAC_W;
            gt_ctr[k] = taps.nb[k] > taps.ctr;
            gt_up[k]  = lhs[k] > up_thr;
            gt_lo[k]  = lhs[k] > lo_thr;
        end
    end

    always_comb begin
        code = '0;
        for (int k = 0; k < NB_N; k++) begin
            if (cfg.mode_two_bit) begin
                code[2*k +: 2] = gt_up[k] ? 2'd2 : (gt_lo[k] ? 2'd1 : 2'd0);
            end else begin
                code[k] = gt_ctr[k];
            end
        end
    end

endmodule

// ===== hw/rtl/census_transform_3x3_stream_unit.sv =====
// Top level of the 3x3 census transform: config registers, raster counters,
// window registers, pipeline and result registers. Uses cen_pkg, cen_line_buf,
// cen_code.
//
//  channel   ports                          item
//  input     s_valid s_ready s_data         cen_in_t  (pixel, frame_start)
//  result    m_valid m_ready m_data         cen_out_t (code, center_col, center_row)
//  config    cfg_valid cfg_ready cfg_index cfg_data   register write, always ready
//
// One pixel per cycle while results are taken; a result is registered when its
// pixel's compare stage advances (line store read at accept, compare in the next cycle).
// Border centres produce no result item.
// aresetn (synchronous) clears counters, window, config and valid flags;
// line store contents are not cleared.
// A stalled result holds the pipeline stage behind it; input stalls only then.
module census_transform_3x3_stream_unit
    import cen_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cen_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cen_out_t          m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int CW = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2;
    localparam int WW = $clog2(MAX_WIDTH + 1) + 2;

    // configuration
    logic [IW_W-1:0]   cfg_width_reg;
    logic              cfg_mode_reg;
    logic [GAIN_W-1:0] cfg_upper_reg;
    logic [GAIN_W-1:0] cfg_lower_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg <= RST_IMAGE_WIDTH;
            cfg_mode_reg  <= 1'b0;
            cfg_upper_reg <= RST_UPPER_GAIN;
            cfg_lower_reg <= RST_LOWER_GAIN;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_width_reg <= cfg_data[IW_W-1:0];
                REG_MODE_TWO_BIT: cfg_mode_reg  <= cfg_data[0];
                REG_UPPER_GAIN:   cfg_upper_reg <= cfg_data[GAIN_W-1:0];
                REG_LOWER_GAIN:   cfg_lower_reg <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    logic [WW-1:0] iw_ext;
    logic [WW-1:0] eff_w;

    assign iw_ext = WW'(cfg_width_reg);

    always_comb begin
        if (iw_ext < WW'(MIN_WIDTH)) begin
            eff_w = WW'(MIN_WIDTH);
        end else if (iw_ext > WW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = iw_ext;
        end
    end

    // accept stage: position counters and line store read
    logic             acc;
    logic             s2_adv;
    logic [CW-1:0]    col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [CW-1:0]    c_in;
    logic [ROW_W-1:0] r_in;

    logic             s2_valid_reg;
    logic [PIX_W-1:0] s2_pix_reg;
    logic [CW-1:0]    s2_col_reg;
    logic [ROW_W-1:0] s2_row_reg;

    logic             m_valid_reg, m_valid_next;
    cen_out_t         m_data_reg;

    assign s2_adv  = s2_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s2_valid_reg || s2_adv;
    assign acc     = s_valid && s_ready;

    assign c_in = s_data.frame_start ? '0 : col_count_reg;
    assign r_in = s_data.frame_start ? '0 : row_count_reg;

    always_comb begin
        if (WW'(c_in) + WW'(1) >= eff_w) begin
            col_count_next = '0;
            row_count_next = r_in + ROW_W'(1);
        end else begin
            col_count_next = c_in + CW'(1);
            row_count_next = r_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s2_valid_reg  <= 1'b0;
        end else begin
            if (acc) begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
            if (acc) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_adv) begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s2_pix_reg <= s_data.pixel;
            s2_col_reg <= c_in;
            s2_row_reg <= r_in;
        end
    end

    logic [PIX_W-1:0] lb_mid;
    logic [PIX_W-1:0] lb_top;

    cen_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (acc),
        .rd_addr (c_in),
        .wr_en   (s2_adv),
        .wr_addr (s2_col_reg),
        .wr_a    (s2_pix_reg),
        .wr_b    (lb_mid),
        .mid     (lb_mid),
        .top     (lb_top)
    );

    // compare stage: window, code, result register
    logic [5:0][PIX_W-1:0] win_reg;
    cen_taps_t             taps;
    cen_code_cfg_t         code_cfg;
    logic [CODE_W-1:0]     code;
    logic                  has_res;
    logic [WW-1:0]         col_ext;

    always_comb begin
        taps.ctr   = win_reg[4];
        taps.nb[0] = win_reg[0];
        taps.nb[1] = win_reg[1];
        taps.nb[2] = win_reg[2];
        taps.nb[3] = win_reg[5];
        taps.nb[4] = win_reg[3];
        taps.nb[5] = lb_top;
        taps.nb[6] = lb_mid;
        taps.nb[7] = s2_pix_reg;
    end

    assign code_cfg.mode_two_bit = cfg_mode_reg;
    assign code_cfg.upper_gain   = cfg_upper_reg;
    assign code_cfg.lower_gain   = cfg_lower_reg;

    cen_code u_code (
        .taps (taps),
        .cfg  (code_cfg),
        .code (code)
    );

    assign has_res = (s2_col_reg >= CW'(2)) && (s2_row_reg >= ROW_W'(2));
    assign col_ext = WW'(s2_col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (s2_adv) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= lb_top;
            win_reg[4] <= lb_mid;
            win_reg[5] <= s2_pix_reg;
        end
    end

    always_comb begin
        if (s2_adv && has_res) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv && has_res) begin
            m_data_reg.code       <= code;
            m_data_reg.center_col <= COL_W'(col_ext - WW'(1));
            m_data_reg.center_row <= s2_row_reg - ROW_W'(1);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && !s2_adv |=> s2_valid_reg && $stable(s2_pix_reg)
            && $stable(s2_col_reg))
        else $error("compare stage lost its item while stalled");

    a_ready_only_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s2_valid_reg && m_valid_reg && !m_ready)
        else $error("input refused without a stalled result");

    a_result_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_adv && has_res |=> m_valid_reg)
        else $error("interior centre gave no result");

    a_row_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.center_row != '0)
        else $error("result on top border row");
`endif

endmodule
